FILE: rtl/csma_ca_pkg.sv
// ----------------------------------------------------------------------------
// csma_ca_pkg
// Shared widths, operation codes, access phases and register indexes for the
// channel access contention unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csma_ca_pkg;

	localparam int TIME_BITS_DEF = 48;

	localparam int OP_W       = 3;
	localparam int PHASE_W    = 2;
	localparam int IFS_W      = 20;
	localparam int SLOT_W     = 16;
	localparam int SLOTS_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [OP_W-1:0] {
		OP_START    = 3'd0,
		OP_MEDIUM   = 3'd1,
		OP_CORRUPT  = 3'd2,
		OP_GRANT    = 3'd3,
		OP_COLLIDE  = 3'd4,
		OP_RELEASE  = 3'd5
	} op_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 2'd0,
		PH_DEFER   = 2'd1,
		PH_BACKOFF = 2'd2,
		PH_OWNING  = 2'd3
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] CFG_IFS_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_SLOTS = 2'd2;

	localparam logic [IFS_W-1:0]   IFS_RST   = '0;
	localparam logic [SLOT_W-1:0]  SLOT_RST  = 16'd1;
	localparam logic [SLOTS_W-1:0] INIT_RST  = 10'd15;

endpackage

`default_nettype wire

FILE: rtl/csma_ca_cfg_if.sv
// ----------------------------------------------------------------------------
// csma_ca_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface csma_ca_cfg_if;
	import csma_ca_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/csma_ca_event_if.sv
// ----------------------------------------------------------------------------
// csma_ca_event_if
// Event channel: one word per medium or protocol event.
// ----------------------------------------------------------------------------
`default_nettype none

interface csma_ca_event_if #(
	parameter int TIME_BITS = csma_ca_pkg::TIME_BITS_DEF
);
	import csma_ca_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic                 medium_free;
	logic [TIME_BITS-1:0] now_time;

	modport source (output valid, output operation, output medium_free,
		output now_time, input ready);
	modport sink   (input valid, input operation, input medium_free,
		input now_time, output ready);
endinterface

`default_nettype wire

FILE: rtl/csma_ca_result_if.sv
// ----------------------------------------------------------------------------
// csma_ca_result_if
// Result channel: one word per accepted event.
// ----------------------------------------------------------------------------
`default_nettype none

interface csma_ca_result_if #(
	parameter int TIME_BITS = csma_ca_pkg::TIME_BITS_DEF
);
	import csma_ca_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PHASE_W-1:0]   access_state;
	logic                 request_valid;
	logic [TIME_BITS-1:0] request_time;
	logic                 cancel_request;
	logic                 access_granted;
	logic                 collision_report;
	logic                 protocol_error;
	logic [SLOTS_W-1:0]   slots_left;

	modport source (output valid, output access_state, output request_valid,
		output request_time, output cancel_request, output access_granted,
		output collision_report, output protocol_error, output slots_left,
		input ready);
	modport sink   (input valid, input access_state, input request_valid,
		input request_time, input cancel_request, input access_granted,
		input collision_report, input protocol_error, input slots_left,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/csma_channel_access_fsm_unit.sv
// ----------------------------------------------------------------------------
// csma_channel_access_fsm_unit
// Channel access contention state machine (idle, defer, ifs_backoff, owning)
// with a bit-serial slot multiplier and a bit-serial slot divider.
// ----------------------------------------------------------------------------
// Sequence: an event without timing work goes straight to FIN; a scheduled request
// runs MUL and ADD first, and a busy medium that trims the slots runs DIV and TRIM (bit-serial divide).
// Throughput: one event at a time; the next event is taken as soon as the result
// sits in the output register, even while it waits there to be taken.
// Reset (arst_n low): phase idle, medium free, zero slots, zero planned time,
// ifs_time 0, slot_time 1, initial_backoff_slots 15.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_channel_access_fsm_unit #(
	parameter int TIME_BITS = csma_ca_pkg::TIME_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	csma_ca_cfg_if.sink           cfg,
	csma_ca_event_if.sink         ev,
	csma_ca_result_if.source      res
);
	import csma_ca_pkg::*;

	localparam int STEP_W = $clog2(TIME_BITS);
	localparam int MUL_W  = SLOT_W + SLOTS_W;
	localparam int WAIT_W = MUL_W + 1;
	localparam int SUM_W  = (TIME_BITS > WAIT_W) ? TIME_BITS + 1 : WAIT_W + 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ADD  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_TRIM = 6'b010000,
		ST_FIN  = 6'b100000
	} ctl_state_t;

	typedef struct packed {
		logic rv;
		logic cancel;
		logic grant;
		logic coll;
		logic err;
	} evt_flags_t;

	// configuration
	logic [IFS_W-1:0]   ifs_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOTS_W-1:0] init_q;

	// contention state
	phase_t               phase_q;
	logic                 medium_q;
	logic [SLOTS_W-1:0]   count_q;
	logic [TIME_BITS-1:0] planned_q;

	// sequencer
	ctl_state_t           st_q;
	logic [STEP_W-1:0]    step_q;
	evt_flags_t           flags_q;
	logic [TIME_BITS-1:0] now_q;
	logic [SLOTS_W-1:0]   mul_sh_q;
	logic [MUL_W-1:0]     mul_acc_q;
	logic [TIME_BITS-1:0] div_sh_q;
	logic [SLOT_W-1:0]    rem_q;
	logic                 neg_q;

	// output register
	logic                 res_valid_q;
	phase_t               res_phase_q;
	evt_flags_t           res_flags_q;
	logic [TIME_BITS-1:0] res_time_q;
	logic [SLOTS_W-1:0]   res_slots_q;

	// decode
	logic                 ev_take;
	phase_t               nxt_phase;
	evt_flags_t           nxt_flags;
	logic                 do_sched;
	logic                 do_trim;
	logic                 load_cnt;
	logic [SLOT_W-1:0]    slot_eff;
	logic [TIME_BITS-1:0] diff;
	logic [SLOT_W:0]      rem_sh;
	logic                 rem_ge;
	logic [SUM_W-1:0]     sum;
	logic [TIME_BITS-1:0] quot;
	logic                 res_free;
	logic                 res_load;

	assign cfg.ready = 1'b1;
	assign ev.ready  = (st_q == ST_IDLE);
	assign ev_take   = ev.valid && ev.ready;
	assign res_free  = !res_valid_q || res.ready;
	assign res_load  = (st_q == ST_FIN) && res_free;

	assign slot_eff = (slot_q == '0) ? SLOT_W'(1) : slot_q;
	assign diff     = planned_q - ev.now_time;
	assign rem_sh   = {rem_q, div_sh_q[TIME_BITS-1]};
	assign rem_ge   = (rem_sh >= {1'b0, slot_eff});
	assign sum      = SUM_W'(now_q) + SUM_W'(ifs_q) + SUM_W'(mul_acc_q);
	assign quot     = div_sh_q + TIME_BITS'(rem_q != '0);

	always_comb begin
		nxt_phase = phase_q;
		nxt_flags = '0;
		do_sched  = 1'b0;
		do_trim   = 1'b0;
		load_cnt  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (ev.operation == OP_START) begin
					load_cnt = 1'b1;
					if (medium_q) begin
						nxt_phase    = PH_BACKOFF;
						nxt_flags.rv = 1'b1;
						do_sched     = 1'b1;
					end else begin
						nxt_phase = PH_DEFER;
					end
				end else if (!(ev.operation inside {OP_MEDIUM, OP_CORRUPT, OP_RELEASE})) begin
					nxt_flags.err = 1'b1;
				end
			end
			PH_DEFER: begin
				if (ev.operation == OP_MEDIUM && ev.medium_free) begin
					nxt_phase    = PH_BACKOFF;
					nxt_flags.rv = 1'b1;
					do_sched     = 1'b1;
				end else if (ev.operation != OP_CORRUPT) begin
					nxt_flags.err = 1'b1;
				end
			end
			PH_BACKOFF: begin
				if (ev.operation == OP_GRANT) begin
					nxt_phase       = PH_OWNING;
					nxt_flags.grant = 1'b1;
				end else if (ev.operation == OP_MEDIUM && !ev.medium_free) begin
					nxt_phase        = PH_DEFER;
					nxt_flags.cancel = 1'b1;
					do_trim          = 1'b1;
				end else if (ev.operation == OP_COLLIDE) begin
					nxt_phase      = PH_IDLE;
					nxt_flags.coll = 1'b1;
				end else if (ev.operation == OP_CORRUPT) begin
					nxt_flags.cancel = 1'b1;
					nxt_flags.rv     = 1'b1;
					do_sched         = 1'b1;
				end else begin
					nxt_flags.err = 1'b1;
				end
			end
			PH_OWNING: begin
				if (ev.operation == OP_RELEASE) begin
					nxt_phase = PH_IDLE;
				end else if (!(ev.operation inside {OP_MEDIUM, OP_CORRUPT})) begin
					nxt_flags.err = 1'b1;
				end
			end
			default: begin
				nxt_flags.err = 1'b1;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifs_q  <= IFS_RST;
			slot_q <= SLOT_RST;
			init_q <= INIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_IFS_TIME:   ifs_q  <= cfg.data[IFS_W-1:0];
				CFG_SLOT_TIME:  slot_q <= cfg.data[SLOT_W-1:0];
				CFG_INIT_SLOTS: init_q <= cfg.data[SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	// control and contention state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			phase_q     <= PH_IDLE;
			medium_q    <= 1'b1;
			count_q     <= '0;
			planned_q   <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (ev_take) begin
						phase_q <= nxt_phase;
						if (ev.operation == OP_MEDIUM)
							medium_q <= ev.medium_free;
						if (load_cnt)
							count_q <= init_q;
						step_q <= '0;
						if (do_sched)
							st_q <= ST_MUL;
						else if (do_trim)
							st_q <= ST_DIV;
						else
							st_q <= ST_FIN;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SLOTS_W - 1))
						st_q <= ST_ADD;
				end
				ST_ADD: begin
					planned_q <= sum[TIME_BITS-1:0];
					st_q      <= ST_FIN;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(TIME_BITS - 1))
						st_q <= ST_TRIM;
				end
				ST_TRIM: begin
					// remaining time already past: no slots left
					if (neg_q)
						count_q <= '0;
					else if (quot < TIME_BITS'(count_q))
						count_q <= quot[SLOTS_W-1:0];
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_free)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: serial multiplier, serial divider, event word
	always_ff @(posedge clk) begin
		if (ev_take) begin
			flags_q   <= nxt_flags;
			now_q     <= ev.now_time;
			mul_sh_q  <= load_cnt ? init_q : count_q;
			mul_acc_q <= '0;
			div_sh_q  <= diff;
			neg_q     <= diff[TIME_BITS-1];
			rem_q     <= '0;
		end
		if (st_q == ST_MUL) begin
			// MSB-first shift-add of slots * slot time
			mul_acc_q <= {mul_acc_q[MUL_W-2:0], 1'b0}
				+ (mul_sh_q[SLOTS_W-1] ? MUL_W'(slot_eff) : '0);
			mul_sh_q  <= {mul_sh_q[SLOTS_W-2:0], 1'b0};
		end
		if (st_q == ST_DIV) begin
			// restoring division, quotient bits shift in behind the dividend
			rem_q    <= rem_ge ? SLOT_W'(rem_sh - {1'b0, slot_eff}) : rem_sh[SLOT_W-1:0];
			div_sh_q <= {div_sh_q[TIME_BITS-2:0], rem_ge};
		end
		if (res_load) begin
			res_phase_q <= phase_q;
			res_flags_q <= flags_q;
			res_time_q  <= flags_q.rv ? planned_q : '0;
			res_slots_q <= count_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.access_state     = res_phase_q;
	assign res.request_valid    = res_flags_q.rv;
	assign res.request_time     = res_time_q;
	assign res.cancel_request   = res_flags_q.cancel;
	assign res.access_granted   = res_flags_q.grant;
	assign res.collision_report = res_flags_q.coll;
	assign res.protocol_error   = res_flags_q.err;
	assign res.slots_left       = res_slots_q;

endmodule

`default_nettype wire
